// ===== hw/rtl/ppp_pkg.sv =====
// ---------------------------------------------------------------------------
// ppp_pkg: shared types and constants for the publish packet parser
// Word formats of both channels, parser phases, result codes, queue sizes.
// ---------------------------------------------------------------------------
package ppp_pkg;

  // Queue sizes: depth must stay a power of two so pointers wrap naturally
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  localparam logic [3:0] PKT_TYPE_PUBLISH = 4'h3;
  localparam logic [1:0] QOS_NONE         = 2'd0;
  localparam logic [1:0] QOS_INVALID      = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_TLEN_HI = 3'd2,
    PH_TLEN_LO = 3'd3,
    PH_TOPIC   = 3'd4,
    PH_ID_HI   = 3'd5,
    PH_ID_LO   = 3'd6,
    PH_PAYLOAD = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_TOPIC   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ACK     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ACK_NONE   = 2'd0,
    ACK_PUBACK = 2'd1,
    ACK_PUBREC = 2'd2
  } ack_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_LEN_LONG  = 3'd1,
    ERR_QOS3      = 3'd2,
    ERR_TOPIC_LEN = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    kind_e       item_kind;
    logic [7:0]  out_byte;
    logic [27:0] section_index;
    logic        section_last;
    ack_e        ack_kind;
    logic [15:0] packet_ident;
    err_e        error_code;
  } out_item_t;

  // Byte after front-end classification
  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
    logic       is_publish;
    logic [1:0] qos;
  } class_t;

endpackage

// ===== hw/rtl/ppp_front.sv =====
// ---------------------------------------------------------------------------
// ppp_front: input queue and byte classifier
// Accepts wire bytes, decodes packet type and QoS on control bytes and
// queues the classified words for the parser.
// ---------------------------------------------------------------------------
module ppp_front
  import ppp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t item_i,
  output logic     valid_o,
  input  logic     ready_i,
  output class_t   word_o
);

  class_t             mem_q [QDepth];
  logic [QAw-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QCw-1:0]     cnt_q;
  class_t             cls;
  logic               wr_en, rd_en;

  always_comb begin
    cls.data_byte    = item_i.data_byte;
    cls.packet_start = item_i.packet_start;
    cls.is_publish   = (item_i.data_byte[7:4] == PKT_TYPE_PUBLISH);
    cls.qos          = cls.is_publish ? item_i.data_byte[2:1] : QOS_NONE;
  end

  assign full    = (cnt_q == QCw'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign word_o  = mem_q[rd_ptr_q];
  assign wr_en   = push && !full;
  assign rd_en   = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= cls;
  end

endmodule

// ===== hw/rtl/ppp_back.sv =====
// ---------------------------------------------------------------------------
// ppp_back: packet parser state machine
// Walks the length, topic, identifier and payload fields one byte per cycle
// unless the result queue is full; at most one result word per byte.
// ---------------------------------------------------------------------------
module ppp_back
  import ppp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  class_t    word_i,
  input  logic      res_full_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  len_cnt_q, len_cnt_d;
  logic [27:0] rem_q, rem_d;
  logic [15:0] tlen_q, tlen_d;
  logic [27:0] pos_q, pos_d;
  logic [15:0] ident_q, ident_d;
  logic [1:0]  qos_q, qos_d;
  logic        pub_q, pub_d;

  logic        step;
  logic [7:0]  b;
  logic [27:0] len_part;
  logic [27:0] rem_dec;
  logic [16:0] need;
  logic [28:0] pos_inc;
  logic        topic_last;

  assign ready_o = !res_full_i;
  assign step    = valid_i && !res_full_i;
  assign b       = word_i.data_byte;
  assign rem_dec = rem_q - 28'd1;
  assign pos_inc = {1'b0, pos_q} + 29'd1;

  always_comb begin
    unique case (len_cnt_q)
      2'd0: len_part = {21'b0, b[6:0]};
      2'd1: len_part = {14'b0, b[6:0], 7'b0};
      2'd2: len_part = {7'b0, b[6:0], 14'b0};
      2'd3: len_part = {b[6:0], 21'b0};
      default: len_part = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cnt_q <= '0;
      rem_q     <= '0;
      tlen_q    <= '0;
      pos_q     <= '0;
      ident_q   <= '0;
      qos_q     <= '0;
      pub_q     <= 1'b0;
    end else begin
      len_cnt_q <= len_cnt_d;
      rem_q     <= rem_d;
      tlen_q    <= tlen_d;
      pos_q     <= pos_d;
      ident_q   <= ident_d;
      qos_q     <= qos_d;
      pub_q     <= pub_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    len_cnt_d   = len_cnt_q;
    rem_d       = rem_q;
    tlen_d      = tlen_q;
    pos_d       = pos_q;
    ident_d     = ident_q;
    qos_d       = qos_q;
    pub_d       = pub_q;
    res_valid_o = 1'b0;
    res_o       = '{item_kind: KIND_TOPIC, ack_kind: ACK_NONE, error_code: ERR_NONE,
                    default: '0};
    need        = '0;
    topic_last  = 1'b0;

    if (step) begin
      if (word_i.packet_start) begin
        // A new control byte cuts short whatever packet was in flight
        if (phase_q != PH_IDLE) begin
          res_valid_o      = 1'b1;
          res_o.item_kind  = KIND_ERROR;
          res_o.error_code = ERR_TRUNCATED;
        end
        pub_d     = word_i.is_publish;
        qos_d     = word_i.qos;
        len_cnt_d = '0;
        rem_d     = '0;
        tlen_d    = '0;
        pos_d     = '0;
        ident_d   = '0;
        phase_d   = PH_LEN;
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            phase_d = PH_IDLE;
          end
          PH_LEN: begin
            rem_d = rem_q | len_part;
            if (b[7]) begin
              if (len_cnt_q == 2'd3) begin
                res_valid_o      = 1'b1;
                res_o.item_kind  = KIND_ERROR;
                res_o.error_code = ERR_LEN_LONG;
                phase_d          = PH_IDLE;
              end else begin
                len_cnt_d = len_cnt_q + 2'd1;
              end
            end else if (!pub_q) begin
              phase_d = PH_IDLE;
            end else if (qos_q == QOS_INVALID) begin
              res_valid_o      = 1'b1;
              res_o.item_kind  = KIND_ERROR;
              res_o.error_code = ERR_QOS3;
              phase_d          = PH_IDLE;
            end else if (rem_d < 28'd2) begin
              res_valid_o      = 1'b1;
              res_o.item_kind  = KIND_ERROR;
              res_o.error_code = ERR_TOPIC_LEN;
              phase_d          = PH_IDLE;
            end else begin
              phase_d = PH_TLEN_HI;
            end
          end
          PH_TLEN_HI: begin
            tlen_d  = {b, 8'h00};
            rem_d   = rem_dec;
            phase_d = PH_TLEN_LO;
          end
          PH_TLEN_LO: begin
            tlen_d = {tlen_q[15:8], b};
            rem_d  = rem_dec;
            need   = {1'b0, tlen_d} + ((qos_q != QOS_NONE) ? 17'd2 : 17'd0);
            pos_d  = '0;
            if ({11'b0, need} > rem_d) begin
              res_valid_o      = 1'b1;
              res_o.item_kind  = KIND_ERROR;
              res_o.error_code = ERR_TOPIC_LEN;
              phase_d          = PH_IDLE;
            end else if (tlen_d != '0) begin
              phase_d = PH_TOPIC;
            end else if (qos_q != QOS_NONE) begin
              phase_d = PH_ID_HI;
            end else begin
              phase_d = (rem_d == '0) ? PH_IDLE : PH_PAYLOAD;
            end
          end
          PH_TOPIC: begin
            topic_last          = (pos_inc >= {13'b0, tlen_q});
            rem_d               = rem_dec;
            pos_d               = pos_inc[27:0];
            res_valid_o         = 1'b1;
            res_o.item_kind     = KIND_TOPIC;
            res_o.out_byte      = b;
            res_o.section_index = pos_q;
            res_o.section_last  = topic_last;
            if (topic_last) begin
              if (qos_q != QOS_NONE) begin
                phase_d = PH_ID_HI;
              end else begin
                pos_d   = '0;
                phase_d = (rem_d == '0) ? PH_IDLE : PH_PAYLOAD;
              end
            end
          end
          PH_ID_HI: begin
            ident_d = {b, 8'h00};
            rem_d   = rem_dec;
            phase_d = PH_ID_LO;
          end
          PH_ID_LO: begin
            ident_d            = {ident_q[15:8], b};
            rem_d              = rem_dec;
            pos_d              = '0;
            phase_d            = (rem_d == '0) ? PH_IDLE : PH_PAYLOAD;
            res_valid_o        = 1'b1;
            res_o.item_kind    = KIND_ACK;
            res_o.ack_kind     = ack_e'(qos_q);
            res_o.packet_ident = ident_d;
          end
          PH_PAYLOAD: begin
            rem_d               = rem_dec;
            pos_d               = pos_inc[27:0];
            res_valid_o         = 1'b1;
            res_o.item_kind     = KIND_PAYLOAD;
            res_o.out_byte      = b;
            res_o.section_index = pos_q;
            res_o.section_last  = (rem_q <= 28'd1);
            if (rem_q <= 28'd1) phase_d = PH_IDLE;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/ppp_out_q.sv =====
// ---------------------------------------------------------------------------
// ppp_out_q: result queue
// Holds parser results until the consumer pops them.
// ---------------------------------------------------------------------------
module ppp_out_q
  import ppp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  out_item_t wr_data_i,
  output logic      full_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t res_o
);

  out_item_t      mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCw-1:0] cnt_q;
  logic           wr_en, rd_en;

  assign full_o = (cnt_q == QCw'(QDepth));
  assign empty  = (cnt_q == '0);
  assign res_o  = mem_q[rd_ptr_q];
  assign wr_en  = wr_i && !full_o;
  assign rd_en  = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// ===== hw/rtl/publish_packet_parser_core.sv =====
// ---------------------------------------------------------------------------
// publish_packet_parser_core: MQTT PUBLISH packet parser
// Splits a byte stream into topic bytes, payload bytes, acknowledgment
// requests and error words.
//
//   channel   direction  handshake           word
//   input     in         push / full         in_item_t  (one wire byte)
//   result    out        empty / pop         out_item_t (zero or one per byte)
//
// One byte per cycle sustained while results are popped. A byte accepted
// goes into the input queue, is parsed combinationally from its head and
// its result is written into the result queue, whose head shows on the
// result ports until popped. full rises only when the result queue stalls
// the parser and the two-word input queue fills behind it.
// Reset clears the queues and the parser state at once; no clearing pass.
// ---------------------------------------------------------------------------
module publish_packet_parser_core
  import ppp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t res_o
);

  logic      fq_valid, fq_ready;
  class_t    fq_word;
  logic      res_valid, oq_full;
  out_item_t res_word;

  ppp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .valid_o (fq_valid),
    .ready_i (fq_ready),
    .word_o  (fq_word)
  );

  ppp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (fq_valid),
    .ready_o     (fq_ready),
    .word_i      (fq_word),
    .res_full_i  (oq_full),
    .res_valid_o (res_valid),
    .res_o       (res_word)
  );

  ppp_out_q u_out_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_valid),
    .wr_data_i (res_word),
    .full_o    (oq_full),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res_o)
  );

endmodule

// ===== hw/rtl/ppp_checker.sv =====
// ---------------------------------------------------------------------------
// ppp_checker: port-level checks for the publish packet parser
// Empty after reset, result hold, field combinations the parser never makes.
// ---------------------------------------------------------------------------
module ppp_checker
  import ppp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t res_o
);

  // Nothing can be waiting right after reset
  a_empty_after_reset: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(res_o))
    else $error("waiting result changed before pop");

  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && res_o.item_kind == KIND_ERROR |->
      res_o.error_code != ERR_NONE && res_o.out_byte == '0 &&
      res_o.ack_kind == ACK_NONE && res_o.packet_ident == '0)
    else $error("malformed error word");

  a_ack_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && res_o.item_kind == KIND_ACK |->
      (res_o.ack_kind == ACK_PUBACK || res_o.ack_kind == ACK_PUBREC) &&
      res_o.error_code == ERR_NONE && res_o.section_index == '0)
    else $error("malformed acknowledgment word");

  a_data_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (res_o.item_kind == KIND_TOPIC || res_o.item_kind == KIND_PAYLOAD) |->
      res_o.error_code == ERR_NONE && res_o.ack_kind == ACK_NONE &&
      res_o.packet_ident == '0)
    else $error("malformed data word");

endmodule

bind publish_packet_parser_core ppp_checker u_ppp_checker (.*);
